FILE: design/cblur5_pkg.sv
// Shared constants, codes and helper functions for the circular 5x5 blur unit.
package cblur5_pkg;

    // Frame geometry
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_WIDTH  = 512;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = MAX_HEIGHT * MAX_WIDTH;

    // Field widths
    localparam int SIZE_W  = 10;
    localparam int PIXEL_W = 8;
    localparam int SUM_W   = 15;
    localparam int WGT_W   = 2;
    localparam int PWGT_W  = 2 * WGT_W;
    localparam int PROD_W  = PIXEL_W + PWGT_W;
    localparam int TAP_W   = 3;
    localparam int CNT_W   = $clog2(ROW_W > COL_W ? ROW_W : COL_W);

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(4);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEIGHT = 1'b0,
        CFG_WIDTH  = 1'b1
    } cfg_index_t;

    // Request codes
    typedef enum logic [0:0] {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_type_t;

    // One-dimensional kernel weight 1,2,3,2,1
    function automatic logic [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
        logic [WGT_W-1:0] w;
        unique case (k)
            3'd0:    w = 2'd1;
            3'd1:    w = 2'd2;
            3'd2:    w = 2'd3;
            3'd3:    w = 2'd2;
            3'd4:    w = 2'd1;
            default: w = 2'd0;
        endcase
        return w;
    endfunction

    // Size in use, saturated into [2, maxv]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: design/circular_blur_5x5_unit.sv
// Top level: frame store with a sequenced 5x5 circular-boundary blur read.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  in        input      in_valid / in_stall    req_type, row, col, pixel
//  out       output     out_valid / out_stall  weighted_sum
//  cfg       input      cfg_write_en           cfg_index, cfg_data
//
// A write transaction is one memory write port access.
// A read transaction runs bit-serial row/col reduction and 2 wrap
// adjustments on the shared compare-subtract unit, then 25 fetches through
// the single frame memory port, one drain and one handoff.
// in_stall is high while a read is in progress; out_stall only delays handoff.
// Reset (rst_n low) clears control and sets both sizes to 512; the frame
// store is not cleared.
module circular_blur_5x5_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [cblur5_pkg::ROW_W-1:0]     row,
    input  logic [cblur5_pkg::COL_W-1:0]     col,
    input  logic [cblur5_pkg::PIXEL_W-1:0]   pixel,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cblur5_pkg::SUM_W-1:0]     weighted_sum,
    // configuration
    input  logic                             cfg_write_en,
    input  logic                             cfg_index,
    input  logic [cblur5_pkg::SIZE_W-1:0]    cfg_data
);
    import cblur5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_ROW,
        ST_MOD_COL,
        ST_ADJ_ROW,
        ST_ADJ_COL,
        ST_FETCH,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Registers
    state_t                state_reg, state_next;
    logic [SIZE_W-1:0]     height_cfg_reg, width_cfg_reg;
    logic [ROW_W-1:0]      row_in_reg, row_in_next;
    logic [COL_W-1:0]      col_in_reg, col_in_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [ROW_W-1:0]      r_reg, r_next;
    logic [COL_W-1:0]      c_reg, c_next;
    logic [COL_W-1:0]      c0_reg, c0_next;
    logic [TAP_W-1:0]      ti_reg, ti_next;
    logic [TAP_W-1:0]      tj_reg, tj_next;
    logic [PWGT_W-1:0]     pend_w_reg, pend_w_next;
    logic                  pend_v_reg, pend_v_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]      out_sum_reg, out_sum_next;
    logic [PIXEL_W-1:0]    rd_data_reg;

    // Sizes in use
    logic [SIZE_W-1:0]     size_h, size_w;

    // Shared compare-subtract unit
    logic [SIZE_W-1:0]     cs_a, cs_b, cs_diff, cs_res;
    logic                  cs_ge;

    // Memory port
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [PIXEL_W-1:0]    frame_mem [0:MEM_DEPTH-1];

    logic                  in_accept;
    logic                  bit_in;
    logic [SIZE_W-1:0]     r_inc, c_inc;
    logic [PROD_W-1:0]     prod;

    assign size_h = clamp_size(height_cfg_reg, SIZE_W'(MAX_HEIGHT));
    assign size_w = clamp_size(width_cfg_reg, SIZE_W'(MAX_WIDTH));

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign weighted_sum = out_sum_reg;

    // Compare-subtract: result is a - b when a >= b, else a
    assign cs_ge   = (cs_a >= cs_b);
    assign cs_diff = cs_a - cs_b;
    assign cs_res  = cs_ge ? cs_diff : cs_a;

    // Operand select for the shared unit
    always_comb
    begin
        bit_in = 1'b0;
        cs_a   = '0;
        cs_b   = size_h;
        unique case (state_reg)
            ST_MOD_ROW:
            begin
                bit_in = row_in_reg[bit_cnt_reg];
                cs_a   = {rem_reg[SIZE_W-2:0], bit_in};
                cs_b   = size_h;
            end
            ST_MOD_COL:
            begin
                bit_in = col_in_reg[bit_cnt_reg];
                cs_a   = {rem_reg[SIZE_W-2:0], bit_in};
                cs_b   = size_w;
            end
            ST_ADJ_ROW:
            begin
                cs_a = SIZE_W'(r_reg) + size_h - SIZE_W'(2);
                cs_b = size_h;
            end
            ST_ADJ_COL:
            begin
                cs_a = SIZE_W'(c_reg) + size_w - SIZE_W'(2);
                cs_b = size_w;
            end
            default:
            begin
                cs_a = '0;
                cs_b = size_h;
            end
        endcase
    end

    // Memory port: writes from the input, reads from the tap walk
    assign mem_we   = in_accept && (req_type == REQ_WRITE)
                      && (SIZE_W'(row) < size_h) && (SIZE_W'(col) < size_w);
    assign mem_addr = mem_we ? {row, col} : {r_reg, c_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= pixel;
        else
            rd_data_reg <= frame_mem[mem_addr];
    end

    // Wrapping increments of the row and column pointers
    assign r_inc = SIZE_W'(r_reg) + SIZE_W'(1);
    assign c_inc = SIZE_W'(c_reg) + SIZE_W'(1);

    // Tap product of the previous fetch
    assign prod = PROD_W'(rd_data_reg) * PROD_W'(pend_w_reg);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        row_in_next    = row_in_reg;
        col_in_next    = col_in_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        c0_next        = c0_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        pend_w_next    = pend_w_reg;
        pend_v_next    = 1'b0;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;

        // output register drains independently
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // accumulate the tap fetched last cycle
        if (pend_v_reg)
            acc_next = acc_reg + SUM_W'(prod);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_READ))
                begin
                    row_in_next  = row;
                    col_in_next  = col;
                    bit_cnt_next = CNT_W'(ROW_W - 1);
                    rem_next     = '0;
                    acc_next     = '0;
                    state_next   = ST_MOD_ROW;
                end
            end
            ST_MOD_ROW:
            begin
                rem_next = cs_res;
                if (bit_cnt_reg == '0)
                begin
                    r_next       = cs_res[ROW_W-1:0];
                    rem_next     = '0;
                    bit_cnt_next = CNT_W'(COL_W - 1);
                    state_next   = ST_MOD_COL;
                end
                else
                    bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
            ST_MOD_COL:
            begin
                rem_next = cs_res;
                if (bit_cnt_reg == '0)
                begin
                    c_next     = cs_res[COL_W-1:0];
                    state_next = ST_ADJ_ROW;
                end
                else
                    bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
            ST_ADJ_ROW:
            begin
                // first neighbor row: center minus two, wrapped
                r_next     = cs_res[ROW_W-1:0];
                state_next = ST_ADJ_COL;
            end
            ST_ADJ_COL:
            begin
                c_next     = cs_res[COL_W-1:0];
                c0_next    = cs_res[COL_W-1:0];
                ti_next    = '0;
                tj_next    = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                // memory reads {r, c} this cycle; weight travels alongside
                pend_w_next = PWGT_W'(tap_weight(ti_reg)) * PWGT_W'(tap_weight(tj_reg));
                pend_v_next = 1'b1;
                if (tj_reg == TAP_LAST)
                begin
                    tj_next = '0;
                    c_next  = c0_reg;
                    r_next  = (r_inc == size_h) ? '0 : r_inc[ROW_W-1:0];
                    ti_next = ti_reg + TAP_W'(1);
                    if (ti_reg == TAP_LAST)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    tj_next = tj_reg + TAP_W'(1);
                    c_next  = (c_inc == size_w) ? '0 : c_inc[COL_W-1:0];
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            height_cfg_reg <= SIZE_W'(MAX_HEIGHT);
            width_cfg_reg  <= SIZE_W'(MAX_WIDTH);
            pend_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_HEIGHT: height_cfg_reg <= cfg_data;
                    CFG_WIDTH:  width_cfg_reg  <= cfg_data;
                    default:    height_cfg_reg <= height_cfg_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        row_in_reg  <= row_in_next;
        col_in_reg  <= col_in_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        c0_reg      <= c0_next;
        ti_reg      <= ti_next;
        tj_reg      <= tj_next;
        pend_w_reg  <= pend_w_next;
        acc_reg     <= acc_next;
        out_sum_reg <= out_sum_next;
    end

endmodule

FILE: dv/blur_checker.sv
// Checker for the circular 5x5 blur unit: mirrors the frame, predicts blur sums, compares.
module blur_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           req_type,
    input  logic [cblur5_pkg::ROW_W-1:0]   row,
    input  logic [cblur5_pkg::COL_W-1:0]   col,
    input  logic [cblur5_pkg::PIXEL_W-1:0] pixel,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [cblur5_pkg::SUM_W-1:0]   weighted_sum,
    input  logic                           cfg_write_en,
    input  logic                           cfg_index,
    input  logic [cblur5_pkg::SIZE_W-1:0]  cfg_data,
    output int                             mismatch_count,
    output int                             sums_pending
);
    import cblur5_pkg::*;

    // 1-D kernel gains 1,2,3,2,1 packed 3 bits apiece
    localparam logic [14:0] TAP_GAINS = {3'd1, 3'd2, 3'd3, 3'd2, 3'd1};

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] sum;
    } blur_expect_t;

    logic [PIXEL_W-1:0] frame_copy [MEM_DEPTH];
    logic [SIZE_W-1:0]  height_cfg = SIZE_W'(MAX_HEIGHT);
    logic [SIZE_W-1:0]  width_cfg  = SIZE_W'(MAX_WIDTH);
    blur_expect_t       expected_sums [$];
    blur_expect_t       head;
    blur_expect_t       fresh;
    int                 fail_tally = 0;
    int                 queued = 0;

    assign mismatch_count = fail_tally;
    assign sums_pending   = queued;

    // Register value saturated into the usable range
    function automatic int unsigned span_in_use(input logic [SIZE_W-1:0] v,
                                                input int unsigned limit);
        return (v < 2) ? 2 : ((v > limit) ? limit : int'(v));
    endfunction

    // Weighted 5x5 sum around (r0, c0), neighbors wrapping at the sizes in use
    function automatic logic [SUM_W-1:0] blur_sum_at(input int unsigned r0,
                                                     input int unsigned c0);
        int unsigned h;
        int unsigned w;
        int unsigned rr;
        int unsigned cc;
        int unsigned acc;
        h   = span_in_use(height_cfg, MAX_HEIGHT);
        w   = span_in_use(width_cfg, MAX_WIDTH);
        acc = 0;
        for (int i = 0; i < 5; i++) begin
            rr = (r0 + h + i - 2) % h;
            for (int j = 0; j < 5; j++) begin
                cc = (c0 + w + j - 2) % w;
                acc += TAP_GAINS[3*i +: 3] * TAP_GAINS[3*j +: 3]
                       * frame_copy[rr * MAX_WIDTH + cc];
            end
        end
        return SUM_W'(acc);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            height_cfg = SIZE_W'(MAX_HEIGHT);
            width_cfg  = SIZE_W'(MAX_WIDTH);
            expected_sums.delete();
            queued = 0;
        end
        else begin
            // size register writes
            if (cfg_write_en) begin
                if (cfg_index == CFG_HEIGHT)
                    height_cfg = cfg_data;
                else
                    width_cfg = cfg_data;
            end

            // result transaction against the oldest prediction
            if (out_valid && !out_stall) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, weighted_sum);
                    fail_tally++;
                end
                else begin
                    head = expected_sums.pop_front();
                    if (weighted_sum !== head.sum) begin
                        $display("%0t: blur at (%0d,%0d) expected %0d, got %0d",
                                 $time, head.row, head.col, head.sum, weighted_sum);
                        fail_tally++;
                    end
                end
            end

            // request transaction: store the pixel or predict the sum
            if (in_valid && !in_stall) begin
                if (req_type == REQ_READ) begin
                    fresh.row = row;
                    fresh.col = col;
                    fresh.sum = blur_sum_at(row, col);
                    expected_sums.push_back(fresh);
                end
                else if (row < span_in_use(height_cfg, MAX_HEIGHT)
                         && col < span_in_use(width_cfg, MAX_WIDTH)) begin
                    frame_copy[row * MAX_WIDTH + col] = pixel;
                end
            end
            queued = expected_sums.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Stimulus top for the circular 5x5 blur unit: requests, size changes, back-pressure, verdict.
module testbench;
    import cblur5_pkg::*;

    localparam int ITEM_GOAL    = 650;
    localparam int PHASE_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PIXEL_W-1:0] pixel;
    logic               out_valid;
    logic               out_stall;
    logic [SUM_W-1:0]   weighted_sum;
    logic               cfg_write_en;
    logic               cfg_index;
    logic [SIZE_W-1:0]  cfg_data;
    int                 mismatch_count;
    int                 sums_pending;

    int                 items_sent   = 0;
    int                 results_seen = 0;
    int unsigned        cur_h        = MAX_HEIGHT;
    int unsigned        cur_w        = MAX_WIDTH;
    bit                 no_gaps      = 1'b0;
    bit                 written_map [MEM_DEPTH];

    circular_blur_5x5_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .row          (row),
        .col          (col),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .weighted_sum (weighted_sum),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    blur_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .row            (row),
        .col            (col),
        .pixel          (pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .weighted_sum   (weighted_sum),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .sums_pending   (sums_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Size the block actually uses for a register value
    function automatic int unsigned usable_size(input int unsigned v, input int unsigned limit);
        if (v < 2)
            return 2;
        return (v > limit) ? limit : v;
    endfunction

    // Sender idle cycles: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Register value: mostly tiny frames, some mid and full, some out of range
    function automatic int unsigned pick_size();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 11)
            return $urandom_range(2, 8);
        if (roll < 14)
            return $urandom_range(9, 40);
        if (roll < 16)
            return $urandom_range(41, 512);
        if (roll < 18)
            return $urandom_range(0, 1);
        return $urandom_range(512, 1023);
    endfunction

    // Coordinate inside a size; big frames stay near the origin so windows get reused
    function automatic int unsigned near_index(input int unsigned n);
        if (n <= 32 || $urandom_range(0, 7) == 0)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, 5);
    endfunction

    // One request transaction, after a random gap; returns once accepted
    task automatic send_item(input req_type_t rq, input int unsigned r, input int unsigned c,
                             input int unsigned p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        req_type = rq;
        row      = ROW_W'(r);
        col      = COL_W'(c);
        pixel    = PIXEL_W'(p);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (rq == REQ_WRITE && r < cur_h && c < cur_w)
            written_map[r * MAX_WIDTH + c] = 1'b1;
    endtask

    // Let the block go idle: no offer, no result pending, write latency drained
    task automatic settle_block();
        @(negedge clk);
        in_valid = 1'b0;
        wait (sums_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input cfg_index_t idx, input int unsigned v);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = SIZE_W'(v);
        @(negedge clk);
        cfg_write_en = 1'b0;
        if (idx == CFG_HEIGHT)
            cur_h = usable_size(v, MAX_HEIGHT);
        else
            cur_w = usable_size(v, MAX_WIDTH);
    endtask

    // Fill every never-written neighbor of (r0, c0) so the read stays defined
    task automatic prepare_window(input int unsigned r0, input int unsigned c0);
        int unsigned rr;
        int unsigned cc;
        for (int i = 0; i < 5; i++) begin
            rr = (r0 + cur_h + i - 2) % cur_h;
            for (int j = 0; j < 5; j++) begin
                cc = (c0 + cur_w + j - 2) % cur_w;
                if (!written_map[rr * MAX_WIDTH + cc])
                    send_item(REQ_WRITE, rr, cc, $urandom_range(0, 255));
            end
        end
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned c;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            // read, centered anywhere in 9 bits now and then
            if (cur_h <= 32 && cur_w <= 32 && $urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 511);
                c = $urandom_range(0, 511);
            end
            else begin
                r = near_index(cur_h);
                c = near_index(cur_w);
            end
            prepare_window(r, c);
            send_item(REQ_READ, r, c, $urandom_range(0, 255));
        end
        else if (roll < 62) begin
            // write at any address, often outside the frame and dropped
            send_item(REQ_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 255));
        end
        else begin
            send_item(REQ_WRITE, near_index(cur_h), near_index(cur_w), $urandom_range(0, 255));
        end
    endtask

    // Result side: random stalls, free-running stretches, one long hold-off
    initial
    begin : back_pressure
        int span;
        int mode;
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            // long hold-off while the sender is offering
            if (!held && results_seen >= 30 && in_valid === 1'b1) begin
                held = 1'b1;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                span = $urandom_range(1, 60);
                repeat (span) begin
                    @(negedge clk);
                    out_stall = 1'b0;
                end
            end
            else if (mode < 9) begin
                span = $urandom_range(1, 20);
                repeat (span) begin
                    @(negedge clk);
                    out_stall = ($urandom_range(0, 2) == 0);
                end
            end
            else begin
                span = $urandom_range(20, 80);
                repeat (span) begin
                    @(negedge clk);
                    out_stall = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction; also counts results
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (rst_n) begin
                if (out_valid && !out_stall)
                    results_seen++;
                if ((in_valid && !in_stall) || (out_valid && !out_stall))
                    idle_cycles = 0;
                else
                    idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int          phase;
        int unsigned hv;
        int unsigned wv;
        int          pick;
        in_valid     = 1'b0;
        req_type     = REQ_WRITE;
        row          = '0;
        col          = '0;
        pixel        = '0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_HEIGHT;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: far corners at the reset size
        send_item(REQ_WRITE, 511, 511, 8'h00);
        send_item(REQ_WRITE, 0, 0, 8'hff);

        // directed: register values below range give a 2x2 frame
        settle_block();
        write_size(CFG_HEIGHT, 0);
        write_size(CFG_WIDTH, 1);
        for (int i = 0; i < 4; i++)
            send_item(REQ_WRITE, i / 2, i % 2, 8'hff);
        send_item(REQ_READ, 0, 0, 0);          // largest sum
        send_item(REQ_READ, 511, 511, 8'hff);  // center outside the frame wraps
        send_item(REQ_WRITE, 2, 0, 8'h5a);     // outside rows, dropped
        send_item(REQ_WRITE, 0, 511, 8'h5a);   // outside columns, dropped
        send_item(REQ_WRITE, 511, 511, 8'h33); // outside both, dropped
        send_item(REQ_READ, 1, 1, 0);
        for (int i = 0; i < 4; i++)
            send_item(REQ_WRITE, i / 2, i % 2, 8'h00);
        send_item(REQ_READ, 1, 0, 0);          // all zero
        send_item(REQ_WRITE, 0, 0, 8'ha5);
        send_item(REQ_WRITE, 1, 1, 8'h5a);
        send_item(REQ_READ, 0, 1, 0);
        send_item(REQ_READ, 510, 3, 0);

        // random phases, each after a write of one or both size registers
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            settle_block();
            case (phase)
                0: begin hv = 1023; wv = 513; end
                1: begin hv = 2;    wv = 512; end
                2: begin hv = 512;  wv = 2;   end
                default: begin hv = pick_size(); wv = pick_size(); end
            endcase
            pick = (phase < 3) ? 0 : $urandom_range(0, 5);
            if (pick != 1)
                write_size(CFG_HEIGHT, hv);
            if (pick != 2)
                write_size(CFG_WIDTH, wv);
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < PHASE_ITEMS && items_sent < ITEM_GOAL; k++)
                random_item();
            phase++;
        end

        // drain and verdict
        @(negedge clk);
        in_valid = 1'b0;
        wait (sums_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && sums_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
design/cblur5_pkg.sv
design/circular_blur_5x5_unit.sv
dv/blur_checker.sv
dv/testbench.sv
